/* rtl/linear_interpolation_gap_fill_assert.svh */
// Assertion macros for the checker file of the gap-fill resampler.
`ifndef LINEAR_INTERPOLATION_GAP_FILL_ASSERT_SVH
`define LINEAR_INTERPOLATION_GAP_FILL_ASSERT_SVH

// Same-cycle implication, disabled while rstn is low.
`define LIG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rstn is low.
`define LIG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lig_pkg.sv */
// Shared codes, constants and controller/datapath interface types.
package lig_pkg;

    localparam int QIDX_W = 10;
    localparam int REQ_W  = 2;
    localparam int POS_W  = 2;
    localparam int STAT_W = 3;

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    localparam logic [POS_W-1:0] POS_EXACT    = 2'd0;
    localparam logic [POS_W-1:0] POS_INTERIOR = 2'd1;
    localparam logic [POS_W-1:0] POS_BEFORE   = 2'd2;
    localparam logic [POS_W-1:0] POS_AFTER    = 2'd3;

    localparam logic [STAT_W-1:0] STAT_DONE  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_VALUE = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOVAL = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OOB   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EQT   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FULL  = 3'd5;

    localparam logic [1:0] SRC_ZERO   = 2'd0;
    localparam logic [1:0] SRC_STORED = 2'd1;
    localparam logic [1:0] SRC_CALC   = 2'd2;

    localparam logic [31:0] WINDOW_RESET = 32'd86400;

    typedef struct packed {
        logic              capture;
        logic              cnt_clr;
        logic              cnt_inc;
        logic              ram_we;
        logic              rd_en;
        logic              rd_back;
        logic              ptr_idx;
        logic              ptr_i2p1;
        logic              ptr_i1;
        logic              ptr_inc;
        logic              ptr_dec;
        logic              flags_clr;
        logic              take_p1;
        logic              take_p2;
        logic              lim_load;
        logic              mul_start;
        logic              mul_step;
        logic              div_start;
        logic              div_step;
        logic              res_load;
        logic [STAT_W-1:0] res_status;
        logic [1:0]        res_src;
        logic              out_load;
    } lig_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             cls_exact;
        logic             cls_edge;
        logic             idx_oob;
        logic             full;
        logic             rd_valid;
        logic             ptr_zero;
        logic             ptr_end;
        logic             brk_b;
        logic             brk_f;
        logic             f1;
        logic             f2;
        logic             teq;
        logic             cnt_last;
    } lig_stat_t;

endpackage

/* rtl/lig_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/lig_ctrl.sv */
// Request sequencer: scans, serial multiply/divide steps and result handoff.
module lig_ctrl import lig_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  logic      ext_en,
    input  lig_stat_t stat,
    output lig_cmd_t  cmd
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_EXEC    = 5'd1;
    localparam logic [4:0] ST_IDX_RD  = 5'd2;
    localparam logic [4:0] ST_IDX_CHK = 5'd3;
    localparam logic [4:0] ST_B_RD    = 5'd4;
    localparam logic [4:0] ST_B_CHK   = 5'd5;
    localparam logic [4:0] ST_F_SET   = 5'd6;
    localparam logic [4:0] ST_F_RD    = 5'd7;
    localparam logic [4:0] ST_F_CHK   = 5'd8;
    localparam logic [4:0] ST_PAIR    = 5'd9;
    localparam logic [4:0] ST_X_RD    = 5'd10;
    localparam logic [4:0] ST_X_CHK   = 5'd11;
    localparam logic [4:0] ST_CMP     = 5'd12;
    localparam logic [4:0] ST_MUL     = 5'd13;
    localparam logic [4:0] ST_DIV_LD  = 5'd14;
    localparam logic [4:0] ST_DIV     = 5'd15;
    localparam logic [4:0] ST_FIN     = 5'd16;
    localparam logic [4:0] ST_OUT     = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       xback_reg, xback_next;
    logic       ovalid_reg, ovalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        xback_next  = xback_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.res_src = SRC_ZERO;
                state_next  = ST_OUT;
                case (stat.req)
                    REQ_CLEAR: begin
                        cmd.cnt_clr    = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STAT_DONE;
                    end
                    REQ_APPEND: begin
                        cmd.res_load = 1'b1;
                        if (stat.full) begin
                            cmd.res_status = STAT_FULL;
                        end else begin
                            cmd.ram_we     = 1'b1;
                            cmd.cnt_inc    = 1'b1;
                            cmd.res_status = STAT_DONE;
                        end
                    end
                    REQ_QUERY: begin
                        if (stat.idx_oob) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STAT_OOB;
                        end else begin
                            cmd.ptr_idx   = 1'b1;
                            cmd.flags_clr = 1'b1;
                            state_next    = ST_IDX_RD;
                        end
                    end
                    default: begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STAT_DONE;
                    end
                endcase
            end
            ST_IDX_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_IDX_CHK;
            end
            ST_IDX_CHK: begin
                if (stat.cls_exact && stat.rd_valid) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_VALUE;
                    cmd.res_src    = SRC_STORED;
                    state_next     = ST_OUT;
                end else if (!ext_en && stat.cls_edge) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_NOVAL;
                    state_next     = ST_OUT;
                end else begin
                    state_next = ST_B_RD;
                end
            end
            ST_B_RD: begin
                if (stat.ptr_zero) begin
                    state_next = ST_F_SET;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_back = 1'b1;
                    state_next  = ST_B_CHK;
                end
            end
            ST_B_CHK: begin
                if (stat.brk_b) begin
                    state_next = ST_F_SET;
                end else if (stat.rd_valid) begin
                    cmd.take_p1 = 1'b1;
                    state_next  = ST_F_SET;
                end else begin
                    cmd.ptr_dec = 1'b1;
                    state_next  = ST_B_RD;
                end
            end
            ST_F_SET: begin
                cmd.lim_load = 1'b1;
                cmd.ptr_idx  = 1'b1;
                state_next   = ST_F_RD;
            end
            ST_F_RD: begin
                if (stat.ptr_end) begin
                    state_next = ST_PAIR;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_F_CHK;
                end
            end
            ST_F_CHK: begin
                if (stat.brk_f) begin
                    state_next = ST_PAIR;
                end else if (stat.rd_valid) begin
                    cmd.take_p2 = 1'b1;
                    state_next  = ST_PAIR;
                end else begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = ST_F_RD;
                end
            end
            ST_PAIR: begin
                if ((!ext_en && !(stat.f1 && stat.f2)) || (!stat.f1 && !stat.f2)) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_NOVAL;
                    state_next     = ST_OUT;
                end else if (!stat.f1) begin
                    cmd.ptr_i2p1 = 1'b1;
                    xback_next   = 1'b0;
                    state_next   = ST_X_RD;
                end else if (!stat.f2) begin
                    cmd.ptr_i1 = 1'b1;
                    xback_next = 1'b1;
                    state_next = ST_X_RD;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_X_RD: begin
                if (xback_reg ? stat.ptr_zero : stat.ptr_end) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_NOVAL;
                    state_next     = ST_OUT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_back = xback_reg;
                    state_next  = ST_X_CHK;
                end
            end
            ST_X_CHK: begin
                if (stat.rd_valid) begin
                    cmd.take_p1 = !xback_reg;
                    cmd.take_p2 = xback_reg;
                    state_next  = ST_CMP;
                end else begin
                    cmd.ptr_inc = !xback_reg;
                    cmd.ptr_dec = xback_reg;
                    state_next  = ST_X_RD;
                end
            end
            ST_CMP: begin
                if (stat.teq) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_EQT;
                    state_next     = ST_OUT;
                end else begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (stat.cnt_last) begin
                    state_next = ST_DIV_LD;
                end
            end
            ST_DIV_LD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.cnt_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.res_load   = 1'b1;
                cmd.res_status = STAT_VALUE;
                cmd.res_src    = SRC_CALC;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            xback_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            xback_reg  <= xback_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

/* rtl/lig_dp.sv */
// Datapath: sample store, scan pointer, found points, serial multiply/divide, result registers.
module lig_dp import lig_pkg::*; #(
    parameter int STORE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32,
    parameter int TIME_WIDTH  = 40,
    parameter int IN_DW       = 128,
    parameter int OUT_DW      = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lig_cmd_t          cmd,
    output lig_stat_t         stat,
    input  logic [IN_DW-1:0]  s_tdata,
    input  logic [REQ_W-1:0]  s_tuser,
    input  logic [31:0]       window,
    output logic [OUT_DW-1:0] m_tdata,
    output logic [STAT_W-1:0] m_tuser
);

    localparam int VW = VALUE_WIDTH;
    localparam int TW = TIME_WIDTH;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int XW = (CW > QIDX_W) ? CW : QIDX_W;
    localparam int SW = ((TW > 32) ? TW : 32) + 1;
    localparam int RW = TW + VW + 1;
    localparam int PW = VW + TW;
    localparam int NW = PW + 1;
    localparam int KW = $clog2(NW + 1);
    localparam int O_VAL = TW;
    localparam int O_VLD = TW + VW;
    localparam int O_IDX = O_VLD + 1;
    localparam int O_CLS = O_IDX + QIDX_W;
    localparam int O_QT  = O_CLS + POS_W;

    localparam logic signed [VW+2:0] SUM_HI = {4'b0000, {(VW-1){1'b1}}};
    localparam logic signed [VW+2:0] SUM_LO = {4'b1111, {(VW-1){1'b0}}};
    localparam logic [VW-1:0]        VAL_HI = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0]        VAL_LO = {1'b1, {(VW-1){1'b0}}};
    localparam logic [NW-1:0]        Q_LIM  = NW'(1) << (VW + 1);

    // latched request
    logic [REQ_W-1:0]  req_reg;
    logic [TW-1:0]     st_reg;
    logic [VW-1:0]     sv_reg;
    logic              svld_reg;
    logic [QIDX_W-1:0] idx_reg;
    logic [POS_W-1:0]  cls_reg;
    logic [TW-1:0]     x_reg;

    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     ptr_reg;
    logic [CW-1:0]     ptr_m1;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     rd_addr_reg;
    logic [RW-1:0]     rd_data;
    logic [TW-1:0]     rd_t;
    logic [VW-1:0]     rd_v;
    logic              rd_vld;

    logic              f1_reg, f2_reg;
    logic [TW-1:0]     t1_reg, t2_reg;
    logic [VW-1:0]     y1_reg, y2_reg;
    logic [AW-1:0]     i1_reg, i2_reg;
    logic [SW-1:0]     lim_reg;

    logic [VW-1:0]     ady_reg;
    logic [TW-1:0]     adx_reg;
    logic [TW-1:0]     ad_reg;
    logic              neg_reg;
    logic [PW-1:0]     acc_reg;
    logic [NW-1:0]     n_reg;
    logic [TW:0]       r_reg;
    logic [KW-1:0]     k_reg;

    logic [STAT_W-1:0] pst_reg;
    logic [VW-1:0]     pval_reg;
    logic              psat_reg;
    logic [STAT_W-1:0] ost_reg;
    logic [VW-1:0]     oval_reg;
    logic              osat_reg;

    logic signed [VW:0] dy;
    logic signed [TW:0] dx, dd;
    logic [VW:0]        ady_w;
    logic [TW:0]        adx_w, ad_w;
    logic [TW+1:0]      r_sh;
    logic [TW+1:0]      den;
    logic               ge;
    logic [TW+1:0]      r_sub;
    logic signed [VW+2:0] y1e, qe, sum;
    logic [VW-1:0]      calc_val;
    logic               calc_sat;

    lig_ram #(
        .WIDTH(RW),
        .DEPTH(STORE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (cmd.ram_we),
        .waddr(cnt_reg[AW-1:0]),
        .wdata({svld_reg, sv_reg, st_reg}),
        .re   (cmd.rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    assign ptr_m1  = ptr_reg - 1'b1;
    assign rd_addr = cmd.rd_back ? ptr_m1[AW-1:0] : ptr_reg[AW-1:0];
    assign rd_t    = rd_data[TW-1:0];
    assign rd_v    = rd_data[TW+VW-1:TW];
    assign rd_vld  = rd_data[TW+VW];

    assign stat.req       = req_reg;
    assign stat.cls_exact = (cls_reg == POS_EXACT);
    assign stat.cls_edge  = (cls_reg == POS_BEFORE) || (cls_reg == POS_AFTER);
    assign stat.idx_oob   = XW'(idx_reg) >= XW'(cnt_reg);
    assign stat.full      = (cnt_reg == CW'(STORE_DEPTH));
    assign stat.rd_valid  = rd_vld;
    assign stat.ptr_zero  = (ptr_reg == '0);
    assign stat.ptr_end   = (ptr_reg >= cnt_reg);
    assign stat.brk_b     = (SW'(rd_t) + SW'(window)) < SW'(x_reg);
    assign stat.brk_f     = SW'(rd_t) > lim_reg;
    assign stat.f1        = f1_reg;
    assign stat.f2        = f2_reg;
    assign stat.teq       = (t1_reg == t2_reg);
    assign stat.cnt_last  = (k_reg == KW'(1));

    // differences and magnitudes for the multiply setup
    assign dy    = $signed({y2_reg[VW-1], y2_reg}) - $signed({y1_reg[VW-1], y1_reg});
    assign dx    = $signed({1'b0, x_reg}) - $signed({1'b0, t1_reg});
    assign dd    = $signed({1'b0, t2_reg}) - $signed({1'b0, t1_reg});
    assign ady_w = dy[VW] ? (-dy) : dy;
    assign adx_w = dx[TW] ? (-dx) : dx;
    assign ad_w  = dd[TW] ? (-dd) : dd;

    // restoring divide step against 2*|d|
    assign r_sh  = {r_reg, n_reg[NW-1]};
    assign den   = {1'b0, ad_reg, 1'b0};
    assign ge    = (r_sh >= den);
    assign r_sub = r_sh - den;

    // final sum and clip
    assign y1e = {{3{y1_reg[VW-1]}}, y1_reg};
    assign qe  = {1'b0, n_reg[VW+1:0]};
    assign sum = neg_reg ? (y1e - qe) : (y1e + qe);

    always_comb begin
        calc_sat = 1'b0;
        calc_val = sum[VW-1:0];
        if (n_reg > Q_LIM) begin
            calc_sat = 1'b1;
            calc_val = neg_reg ? VAL_LO : VAL_HI;
        end else if (sum > SUM_HI) begin
            calc_sat = 1'b1;
            calc_val = VAL_HI;
        end else if (sum < SUM_LO) begin
            calc_sat = 1'b1;
            calc_val = VAL_LO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= s_tuser;
            st_reg   <= s_tdata[TW-1:0];
            sv_reg   <= s_tdata[O_VLD-1:O_VAL];
            svld_reg <= s_tdata[O_VLD];
            idx_reg  <= s_tdata[O_CLS-1:O_IDX];
            cls_reg  <= s_tdata[O_QT-1:O_CLS];
            x_reg    <= s_tdata[O_QT+TW-1:O_QT];
        end
        if (cmd.rd_en) begin
            rd_addr_reg <= rd_addr;
        end
        if (cmd.ptr_idx) begin
            ptr_reg <= CW'(idx_reg);
        end else if (cmd.ptr_i2p1) begin
            ptr_reg <= CW'(i2_reg) + 1'b1;
        end else if (cmd.ptr_i1) begin
            ptr_reg <= CW'(i1_reg);
        end else if (cmd.ptr_inc) begin
            ptr_reg <= ptr_reg + 1'b1;
        end else if (cmd.ptr_dec) begin
            ptr_reg <= ptr_m1;
        end
        if (cmd.flags_clr) begin
            f1_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        if (cmd.take_p1) begin
            f1_reg <= 1'b1;
            t1_reg <= rd_t;
            y1_reg <= rd_v;
            i1_reg <= rd_addr_reg;
        end
        if (cmd.take_p2) begin
            f2_reg <= 1'b1;
            t2_reg <= rd_t;
            y2_reg <= rd_v;
            i2_reg <= rd_addr_reg;
        end
        if (cmd.lim_load) begin
            lim_reg <= SW'(f1_reg ? t1_reg : x_reg) + SW'(window);
        end
        if (cmd.mul_start) begin
            ady_reg <= ady_w[VW-1:0];
            adx_reg <= adx_w[TW-1:0];
            ad_reg  <= ad_w[TW-1:0];
            neg_reg <= dy[VW] ^ dx[TW] ^ dd[TW];
            acc_reg <= '0;
            k_reg   <= KW'(TW);
        end else if (cmd.mul_step) begin
            acc_reg <= {acc_reg[PW-2:0], 1'b0} + (adx_reg[TW-1] ? PW'(ady_reg) : PW'(0));
            adx_reg <= {adx_reg[TW-2:0], 1'b0};
            k_reg   <= k_reg - 1'b1;
        end else if (cmd.div_start) begin
            n_reg <= {acc_reg, 1'b0} + NW'(ad_reg);
            r_reg <= '0;
            k_reg <= KW'(NW);
        end else if (cmd.div_step) begin
            // quotient bits shift in where numerator bits leave
            n_reg <= {n_reg[NW-2:0], ge};
            r_reg <= ge ? r_sub[TW:0] : r_sh[TW:0];
            k_reg <= k_reg - 1'b1;
        end
        if (cmd.res_load) begin
            pst_reg <= cmd.res_status;
            case (cmd.res_src)
                SRC_STORED: begin
                    pval_reg <= rd_v;
                    psat_reg <= 1'b0;
                end
                SRC_CALC: begin
                    pval_reg <= calc_val;
                    psat_reg <= calc_sat;
                end
                default: begin
                    pval_reg <= '0;
                    psat_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.out_load) begin
            ost_reg  <= pst_reg;
            oval_reg <= pval_reg;
            osat_reg <= psat_reg;
        end
    end

    assign m_tdata = OUT_DW'({osat_reg, oval_reg});
    assign m_tuser = ost_reg;

endmodule

/* rtl/linear_interpolation_gap_fill.sv */
// Top level of the linear gap-filling resampler.
//
// Requests arrive on the s_ stream channel: tuser carries the request type
// (clear, append, query), tdata the sample and query fields. Every request
// gives exactly one result on the m_ channel: tuser carries the status,
// tdata the resampled value and the saturation flag.
// Window length and extrapolation enable sit behind an APB port
// (0x0 window seconds, 0x4 extrapolate enable); write them only while idle.
// Clear, append and unused requests pass through the execute state to the output
// state. A query scans the sample store one entry at a time (one store read port,
// registered read): backward from the index, forward from it, and on one side
// further when extrapolating. A computed point then runs a serial multiply and a
// restoring divide. A new request is taken while a finished result waits in the
// output register; a stalled receiver holds the next result back once the second
// one is ready. Reset empties the store (count zero, no clearing pass), drops any
// pending result and restores the register defaults.
module linear_interpolation_gap_fill import lig_pkg::*; #(
    parameter int STORE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32,
    parameter int TIME_WIDTH  = 40
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // sample_time, sample_value, sample_valid, query_index, position_class, query_time
    input  logic [((2*TIME_WIDTH+VALUE_WIDTH+QIDX_W+POS_W+1+7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic [REQ_W-1:0]         s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // result_value, saturated
    output logic [((VALUE_WIDTH+1+7)/8)*8-1:0] m_tdata,
    // status
    output logic [STAT_W-1:0]        m_tuser,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int IN_DW  = ((2*TIME_WIDTH + VALUE_WIDTH + QIDX_W + POS_W + 1 + 7) / 8) * 8;
    localparam int OUT_DW = ((VALUE_WIDTH + 1 + 7) / 8) * 8;

    logic [31:0] window_reg;
    logic        ext_reg;
    lig_cmd_t    cmd;
    lig_stat_t   stat;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {31'b0, ext_reg} : window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            ext_reg    <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                ext_reg <= pwdata[0];
            end else begin
                window_reg <= pwdata;
            end
        end
    end

    lig_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .ext_en  (ext_reg),
        .stat    (stat),
        .cmd     (cmd)
    );

    lig_dp #(
        .STORE_DEPTH(STORE_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH),
        .TIME_WIDTH (TIME_WIDTH),
        .IN_DW      (IN_DW),
        .OUT_DW     (OUT_DW)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .stat   (stat),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .window (window_reg),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

endmodule

/* rtl/lig_checker.sv */
// Port-level checks on the result channel of the resampler, bound to the top level.
`include "linear_interpolation_gap_fill_assert.svh"

module lig_checker import lig_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((VALUE_WIDTH+1+7)/8)*8-1:0]    m_tdata,
    input logic [STAT_W-1:0]                     m_tuser
);

    `LIG_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `LIG_ASSERT_IMP(a_zero, aclk, aresetn, m_tvalid && (m_tuser != STAT_VALUE), m_tdata[VALUE_WIDTH-1:0] == '0, "value nonzero without value status")
    `LIG_ASSERT_IMP(a_sat, aclk, aresetn, m_tvalid && m_tdata[VALUE_WIDTH], m_tuser == STAT_VALUE, "saturation flag without value status")
    `LIG_ASSERT_NXT(a_rst, aclk, 1'b1, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind linear_interpolation_gap_fill lig_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_lig_checker (.*);

/* sim/linear_interpolation_gap_fill_tb.sv */
// Self-checking testbench for the linear gap-filling resampler: stream stimulus, APB setup.
module linear_interpolation_gap_fill_tb;
    import lig_pkg::*;

    localparam int DEPTH = 1024;
    localparam int FILL = 120;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_WINDOW = 3'h0;
    localparam logic [2:0] ADDR_EXTRAP = 3'h4;
    localparam longint unsigned TIME_MAX = 64'hFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 60000;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [31:0]       value;
        logic              sat;
    } result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // sample_time, sample_value, sample_valid, query_index, position_class, query_time
    logic [127:0] s_tdata = '0;
    // req_type
    logic [REQ_W-1:0] s_tuser = REQ_CLEAR;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // result_value, saturated
    logic [39:0] m_tdata;
    // status
    logic [STAT_W-1:0] m_tuser;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    linear_interpolation_gap_fill i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial forever #5 aclk = ~aclk;

    // shadow of the block's state
    logic [39:0]        time_mem [DEPTH];
    logic signed [31:0] value_mem [DEPTH];
    logic               valid_mem [DEPTH];
    int                 sample_cnt = 0;
    longint unsigned    window_cfg = 86400;
    logic               extrap_cfg = 1'b0;

    result_t pending_results[$];
    int  error_count = 0;
    int  quiet_cycles = 0;
    bit  no_idle = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic result_t resample(input int idx, input logic [1:0] cls,
                                         input longint unsigned x);
        result_t r;
        bit f1, f2;
        int i1, i2, k;
        longint unsigned lim, ady, adx, ad;
        longint y1, y2, dy, dx, d, sum, hi_b, lo_b;
        logic [127:0] q;
        bit neg;
        r.status = STAT_DONE; r.value = '0; r.sat = 1'b0;
        f1 = 0; f2 = 0; i1 = 0; i2 = 0;
        hi_b = 64'sd2147483647; lo_b = -64'sd2147483648;
        if (idx >= sample_cnt) begin
            r.status = STAT_OOB;
            return r;
        end
        if (cls == POS_EXACT && valid_mem[idx]) begin
            r.status = STAT_VALUE; r.value = value_mem[idx];
            return r;
        end
        r.status = STAT_NOVAL;
        if (!extrap_cfg && (cls == POS_BEFORE || cls == POS_AFTER)) return r;
        for (k = idx - 1; k >= 0; k--) begin
            if (longint'(time_mem[k]) + window_cfg < x) break;
            if (valid_mem[k]) begin f1 = 1; i1 = k; break; end
        end
        lim = (f1 ? longint'(time_mem[i1]) : x) + window_cfg;
        for (k = idx; k < sample_cnt; k++) begin
            if (longint'(time_mem[k]) > lim) break;
            if (valid_mem[k]) begin f2 = 1; i2 = k; break; end
        end
        if (!extrap_cfg && (!f1 || !f2)) return r;
        if (!f1 && !f2) return r;
        // one-sided: walk further out on the side that was found
        if (!f1) begin
            for (k = i2 + 1; k < sample_cnt; k++)
                if (valid_mem[k]) begin f1 = 1; i1 = k; break; end
        end else if (!f2) begin
            for (k = i1 - 1; k >= 0; k--)
                if (valid_mem[k]) begin f2 = 1; i2 = k; break; end
        end
        if (!f1 || !f2) return r;
        if (time_mem[i1] == time_mem[i2]) begin
            r.status = STAT_EQT;
            return r;
        end
        r.status = STAT_VALUE;
        y1 = value_mem[i1]; y2 = value_mem[i2];
        dy = y2 - y1;
        dx = longint'(x) - longint'(time_mem[i1]);
        d = longint'(time_mem[i2]) - longint'(time_mem[i1]);
        neg = ((dy < 0) != (dx < 0)) != (d < 0);
        ady = dy < 0 ? -dy : dy;
        adx = dx < 0 ? -dx : dx;
        ad = d < 0 ? -d : d;
        if (ady == 0 || adx == 0) q = '0;
        else q = (128'(ady) * 128'(adx) * 2 + 128'(ad)) / (128'(ad) * 2);
        if (q > (128'd1 << 33)) begin
            r.value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF; r.sat = 1'b1;
            return r;
        end
        sum = neg ? y1 - longint'(q) : y1 + longint'(q);
        if (sum > hi_b) begin sum = hi_b; r.sat = 1'b1; end
        if (sum < lo_b) begin sum = lo_b; r.sat = 1'b1; end
        r.value = sum[31:0];
        return r;
    endfunction

    function automatic result_t predict_request(input logic [1:0] req, input logic [39:0] t,
            input logic [31:0] v, input logic ok, input logic [9:0] idx,
            input logic [1:0] cls, input logic [39:0] qt);
        result_t r;
        r.status = STAT_DONE; r.value = '0; r.sat = 1'b0;
        case (req)
            REQ_CLEAR: sample_cnt = 0;
            REQ_APPEND: begin
                if (sample_cnt >= DEPTH) r.status = STAT_FULL;
                else begin
                    time_mem[sample_cnt] = t; value_mem[sample_cnt] = v;
                    valid_mem[sample_cnt] = ok; sample_cnt++;
                end
            end
            REQ_QUERY: r = resample(idx, cls, qt);
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called just after a falling edge; leaves tvalid high after acceptance
    task automatic send_request(input logic [1:0] req, input logic [39:0] t,
            input logic [31:0] v, input logic ok, input logic [9:0] idx,
            input logic [1:0] cls, input logic [39:0] qt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser = req;
        s_tdata = {3'b0, qt, cls, idx, ok, v, t};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.insert(pending_results.size(),
                               predict_request(req, t, v, ok, idx, cls, qt));
        @(negedge aclk);
    endtask

    task automatic append(input longint unsigned t, input logic [31:0] v, input logic ok);
        send_request(REQ_APPEND, t[39:0], v, ok, 10'($urandom), 2'($urandom),
                     40'($urandom));
    endtask

    task automatic query(input int idx, input logic [1:0] cls, input longint unsigned qt);
        send_request(REQ_QUERY, 40'($urandom), $urandom, 1'($urandom), idx[9:0], cls,
                     qt[39:0]);
    endtask

    task automatic send_random(input logic [1:0] req);
        send_request(req, 40'($urandom), $urandom, 1'($urandom), 10'($urandom),
                     2'($urandom), 40'($urandom));
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_results.size() > 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == ADDR_WINDOW) window_cfg = data;
        else extrap_cfg = data[0];
    endtask

    task automatic configure(input logic [31:0] window, input logic extrap);
        drain();
        apb_write(ADDR_WINDOW, window);
        apb_write(ADDR_EXTRAP, {31'b0, extrap});
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        if (no_idle) m_tready <= 1'b1;
        else if ($urandom_range(0, 99) < 3) m_tready <= 1'b0;
        else if (!m_tready && $urandom_range(0, 99) < 8) m_tready <= 1'b1;
        else if (m_tready) m_tready <= $urandom_range(0, 99) < 80;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", m_tuser, 0);
            end else begin
                result_t want;
                want = pending_results.pop_front();
                if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
                if (m_tdata[31:0] !== want.value)
                    report_mismatch("value", $signed(m_tdata[31:0]), $signed(want.value));
                if (m_tdata[32] !== want.sat) report_mismatch("saturated", m_tdata[32], want.sat);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_basic();
        configure(32'd86400, 1'b0);
        send_request(REQ_CLEAR, '0, '0, 1'b0, '0, '0, '0);
        query(0, POS_EXACT, 0);                          // empty store
        append(1000, 32'sd65536, 1);
        append(2000, 32'h0000_0000, 0);                  // nodata
        append(3000, -32'sd131072, 1);
        append(3000, 32'sd5, 1);                          // equal timestamp
        append(5000, 32'h7FFF_FFFF, 1);
        append(6000, 32'h8000_0000, 1);
        query(0, POS_EXACT, 1000);                        // valid exact
        query(1, POS_EXACT, 2000);                        // exact on nodata
        query(1, POS_INTERIOR, 1500);
        query(4, POS_INTERIOR, 4500);
        query(3, POS_INTERIOR, 3000);                     // equal times
        query(0, POS_BEFORE, 500);
        query(5, POS_AFTER, 7000);
        query(6, POS_INTERIOR, 6500);                     // index out of range
        query(1023, POS_AFTER, TIME_MAX);
        send_request(REQ_UNUSED, '1, '1, 1'b1, '1, '1, '1);
    endtask

    task automatic test_extrapolation();
        configure(32'd86400, 1'b1);
        query(0, POS_BEFORE, 0);
        query(5, POS_AFTER, 7000);
        query(5, POS_AFTER, TIME_MAX);                    // far outside window
        query(0, POS_BEFORE, 990);
        send_request(REQ_CLEAR, '0, '0, 1'b0, '0, '0, '0);
        append(100, 32'sd100, 1);
        append(200, -32'sd2147483648, 1);
        append(300, 32'sd2147483647, 1);
        query(2, POS_AFTER, 1_000_000);                   // no later sample: no value
        query(0, POS_BEFORE, 0);
        query(1, POS_INTERIOR, 150);
    endtask

    task automatic test_window_extremes();
        configure(32'd0, 1'b0);
        send_request(REQ_CLEAR, '0, '0, 1'b0, '0, '0, '0);
        append(TIME_MAX - 30, 32'sd7, 1);
        append(TIME_MAX - 20, 32'sd0, 0);
        append(TIME_MAX, -32'sd9, 1);
        query(1, POS_INTERIOR, TIME_MAX - 20);
        query(2, POS_INTERIOR, TIME_MAX - 10);
        configure(32'hFFFF_FFFF, 1'b0);
        query(1, POS_INTERIOR, TIME_MAX - 20);
        query(2, POS_EXACT, TIME_MAX);
        configure(32'hFFFF_FFFF, 1'b1);
        query(2, POS_AFTER, TIME_MAX);
        query(0, POS_BEFORE, 0);
    endtask

    task automatic test_long_scan();
        int n;
        configure(32'd50, 1'b1);
        no_idle = 1'b1;
        send_request(REQ_CLEAR, '0, '0, 1'b0, '0, '0, '0);
        for (n = 0; n < FILL; n++)
            append(64'd1000 + n * 10, $urandom, n % 37 == 0);
        no_idle = 1'b0;
        append(50000, 32'sd1, 1);
        drain();                                          // hold off until all results are in
        query(FILL - 1, POS_AFTER, 1000 + FILL * 10);
        query(1, POS_INTERIOR, 1005);
        query(FILL / 2, POS_INTERIOR, 995 + FILL * 5);
        query(FILL - 1, POS_EXACT, 1000 + (FILL - 1) * 10);
    endtask

    task automatic test_random();
        int phase, n, m, k, idx;
        longint unsigned t, qt, spread;
        logic [31:0] windows [6];
        windows = '{32'd0, 32'd1, 32'd86400, 32'hFFFF_FFFF, 32'd500, 32'd20000};
        for (phase = 0; phase < 8; phase++) begin
            configure(phase < 6 ? windows[phase] : $urandom_range(0, 100000),
                      phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom));
            no_idle = (phase == 3);
            send_random(REQ_CLEAR);
            t = {$urandom_range(0, 255), $urandom};
            if (t > TIME_MAX - 2_000_000) t -= 2_000_000;
            n = $urandom_range(2, 10);
            for (k = 0; k < n; k++) begin
                t += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30000);
                append(t, $urandom, $urandom_range(0, 99) < 70);
            end
            m = $urandom_range(6, 9);
            for (k = 0; k < m; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_random($urandom_range(0, 9) == 0 ? REQ_UNUSED : REQ_QUERY);
                    continue;
                end
                idx = $urandom_range(0, sample_cnt - 1);
                spread = $urandom_range(0, 40000);
                qt = time_mem[idx];
                qt = ($urandom_range(0, 1) && spread <= qt) ? qt - spread : qt + spread;
                if (qt > TIME_MAX) qt = TIME_MAX;
                query(idx, 2'($urandom), qt);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_basic();
        test_extrapolation();
        test_window_extremes();
        test_long_scan();
        test_random();
        drain();
        repeat (40) @(negedge aclk);
        if (error_count == 0 && pending_results.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
